// ===== src/brpc_pkg.sv =====
// ----------------------------------------------------------------------------
// brpc_pkg: shared types and constants for the button and reed port controller
// Holds the configuration register map, reset values and a small helper
// function used by the controller and its register file.
// ----------------------------------------------------------------------------
package brpc_pkg;

  localparam int unsigned TickW   = 16;
  localparam int unsigned PortW   = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TickW-1:0] TickMax = '1;

  localparam logic [TickW-1:0] ButtonDebounceReset = 16'd50;
  localparam logic [TickW-1:0] LongPressReset      = 16'd3000;
  localparam logic [TickW-1:0] ReedDebounceReset   = 16'd50;

  localparam logic [PortW-1:0] PumpBit   = 8'h01;
  localparam logic [PortW-1:0] DeviceBit = 8'h02;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BUTTON_DEBOUNCE = 2'd0,
    CFG_LONG_PRESS      = 2'd1,
    CFG_REED_DEBOUNCE   = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [TickW-1:0] button_debounce_ticks;
    logic [TickW-1:0] long_press_ticks;
    logic [TickW-1:0] reed_debounce_ticks;
  } cfg_regs_t;

  // Increment that sticks at the top of the 16-bit range.
  function automatic logic [TickW-1:0] sat_inc(input logic [TickW-1:0] v);
    return (v == TickMax) ? v : v + 16'd1;
  endfunction

endpackage

// ===== src/brpc_sample_if.sv =====
// ----------------------------------------------------------------------------
// brpc_sample_if: tick sample channel
// Carries one tick of raw switch levels and an optional port command.
// ----------------------------------------------------------------------------
interface brpc_sample_if;
  logic                      valid;
  logic                      ready;
  logic                      button_level;
  logic                      reed_level;
  logic                      cmd_valid;
  logic [brpc_pkg::PortW-1:0] cmd_value;

  modport source (output valid, output button_level, output reed_level,
                  output cmd_valid, output cmd_value, input ready);
  modport sink   (input valid, input button_level, input reed_level,
                  input cmd_valid, input cmd_value, output ready);
endinterface

// ===== src/brpc_result_if.sv =====
// ----------------------------------------------------------------------------
// brpc_result_if: per-tick result channel
// Carries the drive outputs and the status report fields for one tick.
// ----------------------------------------------------------------------------
interface brpc_result_if;
  logic                       valid;
  logic                       ready;
  logic                       pump_on;
  logic                       device_on;
  logic                       report_valid;
  logic [brpc_pkg::PortW-1:0] port_value;
  logic                       reed_open;
  logic [brpc_pkg::TickW-1:0] change_total;

  modport source (output valid, output pump_on, output device_on,
                  output report_valid, output port_value, output reed_open,
                  output change_total, input ready);
  modport sink   (input valid, input pump_on, input device_on,
                  input report_valid, input port_value, input reed_open,
                  input change_total, output ready);
endinterface

// ===== src/brpc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// brpc_cfg_if: configuration write channel
// Carries a register index and the data to write there.
// ----------------------------------------------------------------------------
interface brpc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [brpc_pkg::CfgIdxW-1:0] index;
  logic [brpc_pkg::TickW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/brpc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// brpc_cfg_regs: configuration register file
// Decodes write beats on the configuration channel into the three
// threshold registers. Writes to an unused index are dropped.
// ----------------------------------------------------------------------------
module brpc_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  brpc_cfg_if.sink            cfg,
  output brpc_pkg::cfg_regs_t regs
);

  brpc_pkg::cfg_regs_t regs_q;

  assign cfg.ready = 1'b1;
  assign regs      = regs_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs_q.button_debounce_ticks <= brpc_pkg::ButtonDebounceReset;
      regs_q.long_press_ticks      <= brpc_pkg::LongPressReset;
      regs_q.reed_debounce_ticks   <= brpc_pkg::ReedDebounceReset;
    end else if (cfg.valid) begin
      case (brpc_pkg::cfg_index_t'(cfg.index))
        brpc_pkg::CFG_BUTTON_DEBOUNCE: regs_q.button_debounce_ticks <= cfg.data;
        brpc_pkg::CFG_LONG_PRESS:      regs_q.long_press_ticks      <= cfg.data;
        brpc_pkg::CFG_REED_DEBOUNCE:   regs_q.reed_debounce_ticks   <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/button_reed_port_controller.sv =====
// ----------------------------------------------------------------------------
// button_reed_port_controller: debounced button and reed switch port control
//
//   channel  | role   | beat carries
//   ---------+--------+----------------------------------------------------
//   sample   | sink   | button_level, reed_level, cmd_valid, cmd_value
//   result   | source | pump_on, device_on, report_valid, port_value,
//            |        | reed_open, change_total
//   cfg      | sink   | index, data (three 16-bit thresholds)
//
// A sample beat lands in an input register; when the result register is free
// or being taken, the tick logic updates the controller state and loads the
// result register, and one beat is taken per cycle while the result side keeps up.
// The result register holds while result.ready is low; the input register
// still takes one more beat, after which sample.ready drops.
// Reset is synchronous and puts the valid flags, controller state and thresholds to their defaults.
// ----------------------------------------------------------------------------
module button_reed_port_controller (
  input  logic       clk,
  input  logic       rst,
  brpc_sample_if.sink sample,
  brpc_result_if.source result,
  brpc_cfg_if.sink   cfg
);

  localparam int unsigned TW = brpc_pkg::TickW;
  localparam int unsigned PW = brpc_pkg::PortW;

  brpc_pkg::cfg_regs_t regs;

  brpc_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Input register.
  logic          smp_valid;
  logic          smp_button;
  logic          smp_reed;
  logic          smp_cmd_valid;
  logic [PW-1:0] smp_cmd_value;

  // Result register.
  logic          res_valid;
  logic          res_pump_on;
  logic          res_device_on;
  logic          res_report_valid;
  logic [PW-1:0] res_port_value;
  logic          res_reed_open;
  logic [TW-1:0] res_change_total;

  // Controller state.
  logic          button_prev_raw,    button_prev_raw_next;
  logic          button_stable,      button_stable_next;
  logic [TW-1:0] button_quiet_ticks, button_quiet_ticks_next;
  logic          press_active,       press_active_next;
  logic [TW-1:0] press_length,       press_length_next;
  logic          reed_seen,          reed_seen_next;
  logic          reed_prev_raw,      reed_prev_raw_next;
  logic          reed_stable,        reed_stable_next;
  logic [TW-1:0] reed_quiet_ticks,   reed_quiet_ticks_next;
  logic [PW-1:0] port_reg,           port_reg_next;
  logic [PW-1:0] port_reported,      port_reported_next;
  logic          first_report_pending, first_report_pending_next;
  logic [TW-1:0] change_counter,     change_counter_next;

  logic          advance;
  logic          toggle;
  logic          reed_changed;
  logic          report;
  logic [PW-1:0] port_mid;
  logic [TW-1:0] count_mid;
  logic [TW-1:0] press_len_inc;

  assign advance       = smp_valid && (!res_valid || result.ready);
  assign sample.ready  = !smp_valid || advance;

  always_comb begin
    button_prev_raw_next      = smp_button;
    button_stable_next        = button_stable;
    press_active_next         = press_active;
    reed_seen_next            = 1'b1;
    reed_prev_raw_next        = smp_reed;
    reed_stable_next          = reed_stable;
    reed_quiet_ticks_next     = reed_quiet_ticks;
    toggle                    = 1'b0;
    reed_changed              = 1'b0;

    // Button: quiet count, then acceptance of a new stable level.
    press_len_inc     = press_active ? brpc_pkg::sat_inc(press_length) : press_length;
    press_length_next = press_len_inc;
    button_quiet_ticks_next = (smp_button != button_prev_raw) ? '0
                              : brpc_pkg::sat_inc(button_quiet_ticks);
    if (button_quiet_ticks_next > regs.button_debounce_ticks &&
        smp_button != button_stable) begin
      button_stable_next = smp_button;
      if (!smp_button) begin
        press_active_next = 1'b1;
        press_length_next = '0;
      end else if (press_active) begin
        toggle            = (press_len_inc >= regs.long_press_ticks);
        press_active_next = 1'b0;
        press_length_next = '0;
      end
    end
    port_mid = toggle ? ((port_reg == '0) ? PW'(1) : '0) : port_reg;

    // Reed: the first sample after reset only seeds the debouncer.
    if (!reed_seen) begin
      reed_stable_next      = smp_reed;
      reed_quiet_ticks_next = '0;
    end else begin
      reed_quiet_ticks_next = (smp_reed != reed_prev_raw) ? '0
                              : brpc_pkg::sat_inc(reed_quiet_ticks);
      if (smp_reed != reed_stable &&
          reed_quiet_ticks_next >= regs.reed_debounce_ticks) begin
        reed_stable_next = smp_reed;
        reed_changed     = 1'b1;
      end
    end

    count_mid = change_counter + TW'(toggle) + TW'(reed_changed);

    report = (port_mid != port_reported) || reed_changed || first_report_pending;
    port_reported_next        = report ? port_mid : port_reported;
    first_report_pending_next = report ? 1'b0 : first_report_pending;

    // A command lands after the report fields are taken.
    port_reg_next       = smp_cmd_valid ? smp_cmd_value : port_mid;
    change_counter_next = count_mid + TW'(smp_cmd_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (sample.ready) begin
      smp_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      smp_button    <= sample.button_level;
      smp_reed      <= sample.reed_level;
      smp_cmd_valid <= sample.cmd_valid;
      smp_cmd_value <= sample.cmd_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_pump_on      <= (port_mid & brpc_pkg::PumpBit) == brpc_pkg::PumpBit;
      res_device_on    <= (port_mid & brpc_pkg::DeviceBit) == brpc_pkg::DeviceBit;
      res_report_valid <= report;
      res_port_value   <= port_mid;
      res_reed_open    <= reed_stable_next;
      res_change_total <= count_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      button_prev_raw      <= 1'b1;
      button_stable        <= 1'b1;
      button_quiet_ticks   <= '0;
      press_active         <= 1'b0;
      press_length         <= '0;
      reed_seen            <= 1'b0;
      reed_prev_raw        <= 1'b1;
      reed_stable          <= 1'b1;
      reed_quiet_ticks     <= '0;
      port_reg             <= '0;
      port_reported        <= '0;
      first_report_pending <= 1'b1;
      change_counter       <= '0;
    end else if (advance) begin
      button_prev_raw      <= button_prev_raw_next;
      button_stable        <= button_stable_next;
      button_quiet_ticks   <= button_quiet_ticks_next;
      press_active         <= press_active_next;
      press_length         <= press_length_next;
      reed_seen            <= reed_seen_next;
      reed_prev_raw        <= reed_prev_raw_next;
      reed_stable          <= reed_stable_next;
      reed_quiet_ticks     <= reed_quiet_ticks_next;
      port_reg             <= port_reg_next;
      port_reported        <= port_reported_next;
      first_report_pending <= first_report_pending_next;
      change_counter       <= change_counter_next;
    end
  end

  assign result.valid        = res_valid;
  assign result.pump_on      = res_pump_on;
  assign result.device_on    = res_device_on;
  assign result.report_valid = res_report_valid;
  assign result.port_value   = res_port_value;
  assign result.reed_open    = res_reed_open;
  assign result.change_total = res_change_total;

  // A press can only be open while the debounced button reads pressed.
  a_press_implies_pressed: assert property (@(posedge clk) disable iff (rst)
    press_active |-> !button_stable)
    else $error("press active while button is released");

  // The reed debouncer stays seeded once the first sample went through.
  a_reed_seen_sticks: assert property (@(posedge clk) disable iff (rst)
    reed_seen |=> reed_seen)
    else $error("reed seen flag cleared without reset");

  // The first processed tick always produces a report and clears the flag.
  a_first_report: assert property (@(posedge clk) disable iff (rst)
    (advance && first_report_pending) |-> report ##1 !first_report_pending)
    else $error("first tick did not report");

  // One tick bumps the change counter by at most three.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    advance |=> (TW'(change_counter - $past(change_counter)) <= TW'(3)))
    else $error("change counter jumped too far");

  // A held sample stays in the input register until the result side frees up.
  a_sample_held: assert property (@(posedge clk) disable iff (rst)
    (smp_valid && !advance) |=> smp_valid)
    else $error("input register dropped a waiting beat");

endmodule

// ===== dv/tb_button_reed_port_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_reed_port_controller: self-checking bench for the port controller
// Drives tick beats built from held switch levels with short glitches and
// occasional port commands. A scoreboard predicts the debounce, long-press
// toggle, reed tracking and report flag of every tick and checks each result
// beat. Several threshold settings are visited, including 0 and 65535, and a
// final long hold with a command on every beat ends in a long-press release.
// ----------------------------------------------------------------------------
module tb_button_reed_port_controller;
  import brpc_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;
  localparam int unsigned StallLimit = 3000;

  typedef struct packed {
    logic             button_level;
    logic             reed_level;
    logic             cmd_valid;
    logic [PortW-1:0] cmd_value;
  } tick_sample_t;

  typedef struct packed {
    logic             pump_on;
    logic             device_on;
    logic             report_valid;
    logic [PortW-1:0] port_value;
    logic             reed_open;
    logic [TickW-1:0] change_total;
  } tick_result_t;

  class port_scoreboard;
    logic [TickW-1:0] btn_debounce, long_press, reed_debounce;
    logic             btn_prev, btn_stable, pressing;
    logic [TickW-1:0] btn_quiet, press_len;
    logic             reed_init_done, reed_prev, reed_stable, reed_state;
    logic [TickW-1:0] reed_quiet;
    logic [PortW-1:0] port_val, port_shown;
    logic             first_pending;
    logic [TickW-1:0] change_count;
    tick_result_t     pending_outputs[$];
    int unsigned      errors, checked, reports, toggles, reed_flips;

    function new();
      btn_debounce   = ButtonDebounceReset;
      long_press     = LongPressReset;
      reed_debounce  = ReedDebounceReset;
      btn_prev       = 1'b1;
      btn_stable     = 1'b1;
      btn_quiet      = '0;
      pressing       = 1'b0;
      press_len      = '0;
      reed_init_done = 1'b0;
      reed_prev      = 1'b1;
      reed_stable    = 1'b1;
      reed_quiet     = '0;
      reed_state     = 1'b0;
      port_val       = '0;
      port_shown     = '0;
      first_pending  = 1'b1;
      change_count   = '0;
    endfunction

    function logic [TickW-1:0] step_sat(logic [TickW-1:0] v);
      return (&v) ? v : v + 1'b1;
    endfunction

    function int unsigned pending();
      return pending_outputs.size();
    endfunction

    function void write_register(logic [CfgIdxW-1:0] idx, logic [TickW-1:0] data);
      case (idx)
        CFG_BUTTON_DEBOUNCE: btn_debounce = data;
        CFG_LONG_PRESS:      long_press = data;
        CFG_REED_DEBOUNCE:   reed_debounce = data;
        default: ;
      endcase
    endfunction

    function void note_sample(tick_sample_t s);
      tick_result_t r;
      logic         reed_flip;
      if (pressing) press_len = step_sat(press_len);
      btn_quiet = (s.button_level != btn_prev) ? '0 : step_sat(btn_quiet);
      if (btn_quiet > btn_debounce && s.button_level != btn_stable) begin
        btn_stable = s.button_level;
        if (!s.button_level) begin
          pressing  = 1'b1;
          press_len = '0;
        end else if (pressing) begin
          if (press_len >= long_press) begin
            port_val = (port_val == '0) ? 8'd1 : 8'd0;
            change_count++;
            toggles++;
          end
          pressing  = 1'b0;
          press_len = '0;
        end
      end
      btn_prev = s.button_level;

      // The first reed sample after reset only seeds the tracker.
      reed_flip = 1'b0;
      if (!reed_init_done) begin
        reed_init_done = 1'b1;
        reed_prev      = s.reed_level;
        reed_stable    = s.reed_level;
        reed_state     = s.reed_level;
        reed_quiet     = '0;
      end else begin
        if (s.reed_level != reed_prev) begin
          reed_prev  = s.reed_level;
          reed_quiet = '0;
        end else begin
          reed_quiet = step_sat(reed_quiet);
        end
        if (s.reed_level != reed_stable && reed_quiet >= reed_debounce) begin
          reed_stable = s.reed_level;
          reed_state  = s.reed_level;
          change_count++;
          reed_flips++;
          reed_flip = 1'b1;
        end
      end

      r.report_valid = (port_val != port_shown) || reed_flip || first_pending;
      if (r.report_valid) begin
        port_shown    = port_val;
        first_pending = 1'b0;
      end
      r.pump_on      = (port_val & PumpBit) == PumpBit;
      r.device_on    = (port_val & DeviceBit) == DeviceBit;
      r.port_value   = port_val;
      r.reed_open    = reed_state;
      r.change_total = change_count;
      pending_outputs.push_back(r);

      if (s.cmd_valid) begin
        port_val = s.cmd_value;
        change_count++;
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH on result beat %0d: %s", checked, msg);
    endtask

    task compare_field(string name, logic [TickW-1:0] got, logic [TickW-1:0] want);
      if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task check_result(tick_result_t got);
      tick_result_t want;
      if (pending_outputs.size() == 0) begin
        report_mismatch("result beat arrived with no tick outstanding");
        return;
      end
      want = pending_outputs.pop_front();
      checked++;
      if (want.report_valid) reports++;
      compare_field("pump_on", got.pump_on, want.pump_on);
      compare_field("device_on", got.device_on, want.device_on);
      compare_field("report_valid", got.report_valid, want.report_valid);
      compare_field("port_value", got.port_value, want.port_value);
      compare_field("reed_open", got.reed_open, want.reed_open);
      compare_field("change_total", got.change_total, want.change_total);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  brpc_sample_if sample_ch ();
  brpc_result_if result_ch ();
  brpc_cfg_if    cfg_ch ();

  button_reed_port_controller u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  port_scoreboard sb;
  int unsigned    idle_mode;
  int unsigned    stall_cycles;
  int unsigned    settings_used;
  int unsigned    ticks_sent;
  logic [TickW-1:0] cur_bdeb, cur_lp, cur_rdeb;
  logic           gen_btn, gen_reed;
  int unsigned    btn_left, reed_left;

  tick_sample_t directed [10] = '{
    '{1'b1, 1'b0, 1'b0, 8'h00},  // first reed sample, switch closed
    '{1'b1, 1'b1, 1'b1, 8'hFF},
    '{1'b0, 1'b1, 1'b1, 8'h00},
    '{1'b0, 1'b0, 1'b1, 8'h01},
    '{1'b1, 1'b0, 1'b1, 8'h02},
    '{1'b1, 1'b1, 1'b0, 8'hAA},  // payload without a command is ignored
    '{1'b0, 1'b1, 1'b1, 8'h03},
    '{1'b1, 1'b0, 1'b1, 8'h80},
    '{1'b0, 1'b0, 1'b0, 8'h55},
    '{1'b1, 1'b1, 1'b1, 8'h7F}
  };

  function automatic int unsigned sender_idle_pct();
    return (idle_mode == 0) ? 14 : (idle_mode == 1) ? 45 : 0;
  endfunction

  function automatic int unsigned receiver_stall_pct();
    return (idle_mode == 0) ? 45 : (idle_mode == 1) ? 14 : 0;
  endfunction

  // A low run of length n releases with a press length of n, so aim near the
  // long-press threshold whenever it is small enough to reach.
  function automatic int unsigned button_run(logic lvl);
    int th, lp, n;
    th = int'(cur_bdeb);
    lp = int'(cur_lp);
    if (th > 100) return $urandom_range(1, 30);
    if ($urandom_range(4) == 0) return $urandom_range(1, th + 2);
    if (!lvl && lp <= 100) begin
      n = lp - 2 + int'($urandom_range(0, 4));
      return (n < th + 2) ? th + 2 : n;
    end
    return th + 2 + $urandom_range(0, 8);
  endfunction

  function automatic int unsigned reed_run();
    int th;
    th = int'(cur_rdeb);
    if (th > 100) return $urandom_range(1, 30);
    if ($urandom_range(4) == 0) return $urandom_range(1, (th < 1) ? 1 : th);
    return th + 1 + $urandom_range(0, 5);
  endfunction

  function automatic tick_sample_t next_tick();
    tick_sample_t t;
    if (btn_left == 0) begin
      gen_btn  = ~gen_btn;
      btn_left = button_run(gen_btn);
    end
    btn_left--;
    if (reed_left == 0) begin
      gen_reed  = ~gen_reed;
      reed_left = reed_run();
    end
    reed_left--;
    t.button_level = gen_btn ^ ($urandom_range(39) == 0);
    t.reed_level   = gen_reed ^ ($urandom_range(39) == 0);
    t.cmd_valid    = ($urandom_range(11) == 0);
    case ($urandom_range(5))
      0:       t.cmd_value = 8'h00;
      1:       t.cmd_value = 8'h01;
      2:       t.cmd_value = 8'h02;
      3:       t.cmd_value = 8'h03;
      4:       t.cmd_value = 8'hFF;
      default: t.cmd_value = 8'($urandom_range(255));
    endcase
    return t;
  endfunction

  task automatic drive_tick(input tick_sample_t t);
    while ($urandom_range(99) < sender_idle_pct()) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid        <= 1'b1;
    sample_ch.button_level <= t.button_level;
    sample_ch.reed_level   <= t.reed_level;
    sample_ch.cmd_valid    <= t.cmd_valid;
    sample_ch.cmd_value    <= t.cmd_value;
    do @(posedge clk); while (!sample_ch.ready);
    ticks_sent++;
  endtask

  task automatic drain(input int unsigned extra);
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [TickW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic apply_setting(input logic [TickW-1:0] bdeb, input logic [TickW-1:0] lp,
                               input logic [TickW-1:0] rdeb, input bit spare);
    sample_ch.valid <= 1'b0;
    drain(4);
    put_reg(CFG_BUTTON_DEBOUNCE, bdeb);
    put_reg(CFG_LONG_PRESS, lp);
    put_reg(CFG_REED_DEBOUNCE, rdeb);
    if (spare) put_reg(CfgSpare, 16'hFFFF);
    cfg_ch.valid <= 1'b0;
    cur_bdeb = bdeb;
    cur_lp   = lp;
    cur_rdeb = rdeb;
    settings_used++;
  endtask

  // Each random stretch runs through the three idling patterns in turn.
  task automatic run_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      idle_mode = (i * 3) / n;
      drive_tick(next_tick());
    end
  endtask

  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct());
    end
  end

  // Beat monitor and stall watchdog.
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles = 0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        sb.note_sample('{sample_ch.button_level, sample_ch.reed_level,
                         sample_ch.cmd_valid, sample_ch.cmd_value});
      end
      if (result_ch.valid && result_ch.ready) begin
        sb.check_result('{result_ch.pump_on, result_ch.device_on, result_ch.report_valid,
                          result_ch.port_value, result_ch.reed_open,
                          result_ch.change_total});
      end
      if (cfg_ch.valid && cfg_ch.ready) sb.write_register(cfg_ch.index, cfg_ch.data);
      if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("Timeout: no beat for %0d cycles", stall_cycles);
        $display("tb_button_reed_port_controller failed");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    rst                    <= 1'b1;
    sample_ch.valid        <= 1'b0;
    sample_ch.button_level <= 1'b1;
    sample_ch.reed_level   <= 1'b1;
    sample_ch.cmd_valid    <= 1'b0;
    sample_ch.cmd_value    <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.index           <= CFG_BUTTON_DEBOUNCE;
    cfg_ch.data            <= '0;
    idle_mode     = 0;
    settings_used = 1;
    ticks_sent    = 0;
    cur_bdeb      = ButtonDebounceReset;
    cur_lp        = LongPressReset;
    cur_rdeb      = ReedDebounceReset;
    gen_btn       = 1'b0;
    gen_reed      = 1'b0;
    btn_left      = 0;
    reed_left     = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) drive_tick(directed[i]);
    run_random(300);

    apply_setting(16'd0, 16'd0, 16'd0, 1'b0);
    run_random(300);
    apply_setting(16'd1, 16'd4, 16'd1, 1'b0);
    run_random(350);
    apply_setting(16'd3, 16'd12, 16'd2, 1'b1);
    run_random(350);
    apply_setting(TickMax, 16'd7, 16'd0, 1'b0);
    run_random(150);
    apply_setting(16'd2, TickMax, TickMax, 1'b0);
    run_random(150);
    apply_setting(16'd5, 16'd20, 16'd4, 1'b0);
    run_random(300);

    // Hold a press past the long-press time with a command on every beat,
    // so the release toggles whatever value the last command left.
    apply_setting(16'd0, 16'd64, 16'd0, 1'b0);
    idle_mode = 2;
    for (int unsigned i = 0; i < 80; i++) begin
      drive_tick('{1'b0, 1'b1, 1'b1, 8'($urandom_range(255))});
    end
    repeat (4) drive_tick('{1'b1, 1'b1, 1'b0, 8'h00});

    sample_ch.valid <= 1'b0;
    drain(8);
    $display("Covered %0d ticks under %0d threshold settings, ending with a long held press.",
             ticks_sent, settings_used);
    $display("Checked %0d results: %0d status reports, %0d long-press toggles, %0d reed changes.",
             sb.checked, sb.reports, sb.toggles, sb.reed_flips);
    if (sb.errors == 0) begin
      $display("tb_button_reed_port_controller passed");
    end else begin
      $display("%0d mismatches found", sb.errors);
      $display("tb_button_reed_port_controller failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/brpc_pkg.sv
src/brpc_sample_if.sv
src/brpc_result_if.sv
src/brpc_cfg_if.sv
src/brpc_cfg_regs.sv
src/button_reed_port_controller.sv
dv/tb_button_reed_port_controller.sv
